// ----- hdl/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent in this cycle implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent in this cycle implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/dnsle_pkg.sv -----
// package with shared types and constants of the dns name label encoder
package dnsle_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam logic [BYTE_W-1:0] DOT_CHAR = 8'h2e;
   localparam logic [BYTE_W-1:0] TERM_BYTE = 8'h00;

   // control handed from the sequencer to the row of label cells
   typedef struct packed {
      logic              load;
      logic              shift;
      logic [BYTE_W-1:0] data;
   } cell_ctl_type;

endpackage

// ----- hdl/dns_name_label_encoder.sv -----
// top level of the dns name label encoder
// Takes a dotted name one character per transaction (tlast marks the end of
// the name, its data ignored) and gives the DNS wire form one byte per
// transaction. Characters are taken one per cycle while idle into a chain of
// LABEL_LIMIT-1 cells. A dot or the end of the name flushes a non-empty label:
// the length byte, then each character as the chain shifts towards its head,
// during which no input is taken; the end of a name adds the zero terminator
// (tlast). A label reaching LABEL_LIMIT characters gives one result with tlast
// and tuser set, and input is then dropped until the end of that name.
module dns_name_label_encoder #(
   parameter int unsigned LABEL_LIMIT = 63
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_in
   input  logic       req_tlast,   // end_of_name
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast,   // out_last
   output logic       rsp_tuser    // [0] label_error
);
   import dnsle_pkg::*;

   localparam int unsigned NUM_CELLS = LABEL_LIMIT - 1;
   localparam int unsigned LEN_W     = (LABEL_LIMIT > 2) ? $clog2(LABEL_LIMIT) : 1;

   cell_ctl_type      cell_ctl;
   logic [LEN_W-1:0]  len_q;
   logic [BYTE_W-1:0] cell_q [NUM_CELLS+1];

   // sequencer and result register
   dnsle_ctrl #(
      .LABEL_LIMIT (LABEL_LIMIT),
      .LEN_W       (LEN_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .head_char  (cell_q[0]),
      .cell_ctl   (cell_ctl),
      .len_q      (len_q)
   );

   // tail of the chain feeds zeros
   assign cell_q[NUM_CELLS] = '0;

   // row of label cells, cell 0 at the head
   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      logic sel;
      assign sel = (len_q == LEN_W'(i));
      dnsle_cell u_cell (
         .clock  (clock),
         .ctl    (cell_ctl),
         .sel    (sel),
         .next_q (cell_q[i+1]),
         .q      (cell_q[i])
      );
   end

endmodule

// ----- hdl/dnsle_cell.sv -----
// one label character cell of the shift chain
module dnsle_cell (
   input  logic                       clock,
   input  dnsle_pkg::cell_ctl_type    ctl,
   input  logic                       sel,
   input  logic [dnsle_pkg::BYTE_W-1:0] next_q,
   output logic [dnsle_pkg::BYTE_W-1:0] q
);
   import dnsle_pkg::*;

   logic [BYTE_W-1:0] char_ff;
   logic [BYTE_W-1:0] char_in;

   // shift towards the head during a flush, else take a new character when loaded and selected, else hold
   always_comb begin
      char_in = char_ff;
      if (ctl.shift) begin
         char_in = next_q;
      end else if (ctl.load && sel) begin
         char_in = ctl.data;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
   end

   assign q = char_ff;

endmodule

// ----- hdl/dnsle_ctrl.sv -----
// sequencer: input decode, label length, flush sequencing and result register
module dnsle_ctrl #(
   parameter int unsigned LABEL_LIMIT = 63,
   parameter int unsigned LEN_W       = 6
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [dnsle_pkg::BYTE_W-1:0] req_tdata,
   input  logic                         req_tlast,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [dnsle_pkg::BYTE_W-1:0] rsp_tdata,
   output logic                         rsp_tlast,
   output logic                         rsp_tuser,
   input  logic [dnsle_pkg::BYTE_W-1:0] head_char,
   output dnsle_pkg::cell_ctl_type      cell_ctl,
   output logic [LEN_W-1:0]             len_q
);
   import dnsle_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_LEN  = 5'b00010,
      ST_CHAR = 5'b00100,
      ST_TERM = 5'b01000,
      ST_ERR  = 5'b10000
   } state_type;

   localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(LABEL_LIMIT - 1);
   localparam logic [LEN_W-1:0] LEN_ONE  = LEN_W'(1);

   state_type         state_ff, state_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              disc_ff, disc_in;
   logic              term_ff, term_in;
   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              last_ff, last_in;
   logic              err_ff, err_in;
   logic              accept;
   logic              can_emit;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign can_emit   = !valid_ff || rsp_tready;

   // next state, label length and result register
   always_comb begin
      state_in       = state_ff;
      len_in         = len_ff;
      disc_in        = disc_ff;
      term_in        = term_ff;
      valid_in       = valid_ff && !rsp_tready;
      byte_in        = byte_ff;
      last_in        = last_ff;
      err_in         = err_ff;
      cell_ctl.load  = 1'b0;
      cell_ctl.shift = 1'b0;
      cell_ctl.data  = req_tdata;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority if (req_tlast && disc_ff) begin
                  disc_in = 1'b0;
                  len_in  = '0;
               end else if (req_tlast) begin
                  term_in  = 1'b1;
                  state_in = (len_ff != '0) ? ST_LEN : ST_TERM;
               end else if (disc_ff) begin
                  disc_in = 1'b1;
               end else if (req_tdata == DOT_CHAR) begin
                  term_in = 1'b0;
                  if (len_ff != '0) begin
                     state_in = ST_LEN;
                  end
               end else if (len_ff >= LEN_FULL) begin
                  len_in   = '0;
                  disc_in  = 1'b1;
                  state_in = ST_ERR;
               end else begin
                  cell_ctl.load = 1'b1;
                  len_in        = len_ff + LEN_ONE;
               end
            end
         end
         ST_LEN: begin
            if (can_emit) begin
               valid_in = 1'b1;
               byte_in  = BYTE_W'(len_ff);
               last_in  = 1'b0;
               err_in   = 1'b0;
               state_in = ST_CHAR;
            end
         end
         ST_CHAR: begin
            if (can_emit) begin
               valid_in       = 1'b1;
               byte_in        = head_char;
               last_in        = 1'b0;
               err_in         = 1'b0;
               cell_ctl.shift = 1'b1;
               len_in         = len_ff - LEN_ONE;
               if (len_ff == LEN_ONE) begin
                  state_in = term_ff ? ST_TERM : ST_IDLE;
               end
            end
         end
         ST_TERM: begin
            if (can_emit) begin
               valid_in = 1'b1;
               byte_in  = TERM_BYTE;
               last_in  = 1'b1;
               err_in   = 1'b0;
               state_in = ST_IDLE;
            end
         end
         ST_ERR: begin
            if (can_emit) begin
               valid_in = 1'b1;
               byte_in  = TERM_BYTE;
               last_in  = 1'b1;
               err_in   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         len_ff   <= '0;
         disc_ff  <= 1'b0;
         term_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         disc_ff  <= disc_in;
         term_ff  <= term_in;
         valid_ff <= valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
      err_ff  <= err_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = err_ff;
   assign len_q      = len_ff;

endmodule

// ----- hdl/dnsle_checker.sv -----
// port checker for the dns name label encoder, bound to the top level
`include "assert_macros.svh"

module dnsle_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic       rsp_tuser
);

   // an error transaction closes the name
   `ASSERT_SAME(a_err_is_last, clock, reset, rsp_tvalid && rsp_tuser, rsp_tlast, "error without last")

   // terminator and error transactions carry a zero byte
   `ASSERT_SAME(a_last_is_zero, clock, reset, rsp_tvalid && rsp_tlast, rsp_tdata == 8'h00, "last not zero")

   // a stalled result holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "stalled result changed")

endmodule

bind dns_name_label_encoder dnsle_checker u_dnsle_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
